// File: rtl/core/nnr_pkg.sv
`default_nettype none

package nnr_pkg;

	// field widths fixed by the interface
	localparam int NNR_COORD_W = 9;
	localparam int NNR_DIM_W   = 10;
	localparam int NNR_TRIG_W  = 16;
	localparam int NNR_PIX_W   = 32;
	localparam int NNR_CFG_W   = 16;
	localparam int NNR_IDX_W   = 2;

	// signed doubled offset from the centre, and its product with a trig value
	localparam int NNR_DELTA_W = NNR_DIM_W + 2;
	localparam int NNR_PROD_W  = NNR_DELTA_W + NNR_TRIG_W;

	// wide enough to compare against the largest store dimension
	localparam int NNR_LIM_W = 13;

	// default build
	localparam int NNR_MAX_WIDTH      = 512;
	localparam int NNR_MAX_HEIGHT     = 512;
	localparam int NNR_TRIG_FRAC_BITS = 14;

	// register map
	typedef enum logic [NNR_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_COSINE       = 2'd2,
		CFG_SINE         = 2'd3
	} nnr_cfg_idx_t;

	// word kinds
	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_FETCH = 1'b1
	} nnr_func_t;

	// reset values of the registers
	localparam logic [NNR_DIM_W-1:0]         NNR_RST_WIDTH  = 10'd512;
	localparam logic [NNR_DIM_W-1:0]         NNR_RST_HEIGHT = 10'd512;
	localparam logic signed [NNR_TRIG_W-1:0] NNR_RST_COSINE = 16'sd16384;
	localparam logic signed [NNR_TRIG_W-1:0] NNR_RST_SINE   = 16'sd0;

	// mapping result handed to the store read
	typedef struct packed {
		logic vld;
		logic in_bounds;
	} nnr_map_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/nnr_src_map.sv
`default_nettype none

module nnr_src_map import nnr_pkg::*; #(
	parameter int MAX_WIDTH      = NNR_MAX_WIDTH,
	parameter int MAX_HEIGHT     = NNR_MAX_HEIGHT,
	parameter int TRIG_FRAC_BITS = NNR_TRIG_FRAC_BITS
) (
	input  wire  logic                                  clk,
	input  wire  logic                                  arst_n,
	input  wire  logic                                  issue,
	input  wire  logic [NNR_COORD_W-1:0]                col,
	input  wire  logic [NNR_COORD_W-1:0]                row,
	input  wire  logic [NNR_DIM_W-1:0]                  width,
	input  wire  logic [NNR_DIM_W-1:0]                  height,
	input  wire  logic signed [NNR_TRIG_W-1:0]          cosine,
	input  wire  logic signed [NNR_TRIG_W-1:0]          sine,
	output nnr_map_ctl_t                                ctl,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     addr
);

	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int SUM_W  = ((TRIG_FRAC_BITS + NNR_DELTA_W > NNR_PROD_W) ?
		(TRIG_FRAC_BITS + NNR_DELTA_W) : NNR_PROD_W) + 2;
	localparam int SHIFT  = TRIG_FRAC_BITS + 1;
	localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((1 << SHIFT) - 1);
	localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

	logic                         vld_s1, vld_s2, vld_s3;
	logic [NNR_COORD_W-1:0]       col_s1, row_s1;
	logic signed [NNR_DELTA_W-1:0] dx2, dy2;
	logic signed [NNR_PROD_W-1:0] cdx_s2, sdy_s2, sdx_s2, cdy_s2;
	logic signed [SUM_W-1:0]      off_x, off_y;
	logic signed [SUM_W-1:0]      nx_s3, ny_s3;
	logic signed [SUM_W-1:0]      bias_x, bias_y;
	logic signed [SUM_W-1:0]      src_col, src_row;
	logic                         in_x, in_y;

	// valid bits along the mapping pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// destination position
	always_ff @(posedge clk) begin
		col_s1 <= col;
		row_s1 <= row;
	end

	// doubled offsets from the centre, y axis pointing up
	assign dx2 = $signed({2'b00, col_s1, 1'b0}) - $signed({2'b00, width});
	assign dy2 = $signed({2'b00, height}) - $signed({2'b00, row_s1, 1'b0});

	// four rotation products
	always_ff @(posedge clk) begin
		cdx_s2 <= cosine * dx2;
		sdy_s2 <= sine * dy2;
		sdx_s2 <= sine * dx2;
		cdy_s2 <= cosine * dy2;
	end

	// centre plus one half, scaled by two to the fraction bits plus one
	assign off_x = SUM_W'({1'b0, width} + 11'd1) << TRIG_FRAC_BITS;
	assign off_y = SUM_W'({1'b0, height} + 11'd1) << TRIG_FRAC_BITS;

	// source coordinates before scaling
	always_ff @(posedge clk) begin
		nx_s3 <= SUM_W'(cdx_s2) - SUM_W'(sdy_s2) + off_x;
		ny_s3 <= off_y - SUM_W'(sdx_s2) - SUM_W'(cdy_s2);
	end

	// truncate toward zero: negative values round up before the shift
	assign bias_x  = nx_s3[SUM_W-1] ? BIAS : '0;
	assign bias_y  = ny_s3[SUM_W-1] ? BIAS : '0;
	assign src_col = (nx_s3 + bias_x) >>> SHIFT;
	assign src_row = (ny_s3 + bias_y) >>> SHIFT;

	// frame bounds
	assign in_x = !src_col[SUM_W-1] && (src_col[SUM_W-2:0] < (SUM_W-1)'(width));
	assign in_y = !src_row[SUM_W-1] && (src_row[SUM_W-2:0] < (SUM_W-1)'(height));

	// read request into the frame store
	assign ctl.vld       = vld_s3;
	assign ctl.in_bounds = in_x && in_y;
	assign addr = ADDR_W'(src_row[NNR_DIM_W-1:0]) * ROW_PITCH
		+ ADDR_W'(src_col[NNR_DIM_W-1:0]);

endmodule

`default_nettype wire

// File: rtl/core/nearest_neighbor_rotate_unit.sv
`default_nettype none

// channel   signals                               direction  transfer
// input     start, busy, func, col, row, pixel_in  in         start && !busy
// result    done, pixel_out, in_frame               out        done, one cycle
// config    cfg_we, cfg_index, cfg_data             in         cfg_we
//
// one word is taken every cycle; busy stays low
// a fetch gives its result after three mapping stages (position, products,
// sums, bounds and address from the sums) then the registered store read
// a load, via a pipe as deep as the mapping pipe, is stored at the
// same stage as a fetch reads, so the store sees words in the order taken
// reset clears the registers and pipe valids; the store holds no reset value
// the receiver cannot stall: each result shows for exactly one cycle

module nearest_neighbor_rotate_unit import nnr_pkg::*; #(
	parameter int MAX_WIDTH      = NNR_MAX_WIDTH,
	parameter int MAX_HEIGHT     = NNR_MAX_HEIGHT,
	parameter int TRIG_FRAC_BITS = NNR_TRIG_FRAC_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   func,
	input  wire logic [NNR_COORD_W-1:0] col,
	input  wire logic [NNR_COORD_W-1:0] row,
	input  wire logic [NNR_PIX_W-1:0]   pixel_in,
	input  wire logic                   cfg_we,
	input  wire logic [NNR_IDX_W-1:0]   cfg_index,
	input  wire logic [NNR_CFG_W-1:0]   cfg_data,
	output logic                        done,
	output logic [NNR_PIX_W-1:0]        pixel_out,
	output logic                        in_frame
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0]     ROW_PITCH = ADDR_W'(MAX_WIDTH);
	localparam logic [NNR_LIM_W-1:0] MAXW_L    = NNR_LIM_W'(MAX_WIDTH);
	localparam logic [NNR_LIM_W-1:0] MAXH_L    = NNR_LIM_W'(MAX_HEIGHT);
	localparam logic [NNR_DIM_W-1:0] MAXW_D    = NNR_DIM_W'(MAX_WIDTH);
	localparam logic [NNR_DIM_W-1:0] MAXH_D    = NNR_DIM_W'(MAX_HEIGHT);

	logic [NNR_DIM_W-1:0]         frame_width_q, frame_height_q;
	logic signed [NNR_TRIG_W-1:0] cosine_q, sine_q;
	logic [NNR_DIM_W-1:0]         width_eff, height_eff;
	logic                         accept, load_ok;
	logic                         ld_vld_s1, ld_vld_s2, ld_vld_s3;
	logic [ADDR_W-1:0]            ld_addr_s1, ld_addr_s2, ld_addr_s3;
	logic [NNR_PIX_W-1:0]         ld_pix_s1, ld_pix_s2, ld_pix_s3;
	nnr_map_ctl_t                 map_ctl;
	logic [ADDR_W-1:0]            map_addr;
	logic                         vld_s4, inside_s4;
	logic [NNR_PIX_W-1:0]         rd_data_s4;
	logic [NNR_PIX_W-1:0]         store_mem [DEPTH];

	// a word is taken every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= NNR_RST_WIDTH;
			frame_height_q <= NNR_RST_HEIGHT;
			cosine_q       <= NNR_RST_COSINE;
			sine_q         <= NNR_RST_SINE;
		end else if (cfg_we) begin
			unique case (nnr_cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[NNR_DIM_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[NNR_DIM_W-1:0];
				CFG_COSINE:       cosine_q       <= cfg_data;
				CFG_SINE:         sine_q         <= cfg_data;
			endcase
		end
	end

	// frame size saturated to the store
	assign width_eff  = ({3'b000, frame_width_q} > MAXW_L) ? MAXW_D : frame_width_q;
	assign height_eff = ({3'b000, frame_height_q} > MAXH_L) ? MAXH_D : frame_height_q;

	// loads beyond the store are dropped
	assign load_ok = ({4'b0000, col} < MAXW_L) && ({4'b0000, row} < MAXH_L);

	// load pipe, as deep as the mapping pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_vld_s1 <= 1'b0;
			ld_vld_s2 <= 1'b0;
			ld_vld_s3 <= 1'b0;
		end else begin
			ld_vld_s1 <= accept && (func == FUNC_LOAD) && load_ok;
			ld_vld_s2 <= ld_vld_s1;
			ld_vld_s3 <= ld_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ld_addr_s1 <= ADDR_W'(row) * ROW_PITCH + ADDR_W'(col);
		ld_pix_s1  <= pixel_in;
		ld_addr_s2 <= ld_addr_s1;
		ld_pix_s2  <= ld_pix_s1;
		ld_addr_s3 <= ld_addr_s2;
		ld_pix_s3  <= ld_pix_s2;
	end

	// inverse rotation to a source address
	nnr_src_map #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_src_map (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (accept && (func == FUNC_FETCH)),
		.col    (col),
		.row    (row),
		.width  (width_eff),
		.height (height_eff),
		.cosine (cosine_q),
		.sine   (sine_q),
		.ctl    (map_ctl),
		.addr   (map_addr)
	);

	// frame store: one write port for loads, one registered read for fetches
	always_ff @(posedge clk) begin
		if (ld_vld_s3) begin
			store_mem[ld_addr_s3] <= ld_pix_s3;
		end
		if (map_ctl.vld) begin
			rd_data_s4 <= store_mem[map_addr];
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= map_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		inside_s4 <= map_ctl.in_bounds;
	end

	// result word, zero outside the frame
	assign done      = vld_s4;
	assign in_frame  = inside_s4;
	assign pixel_out = inside_s4 ? rd_data_s4 : '0;

endmodule

`default_nettype wire

// File: rtl/core/nnr_checker.sv
`default_nettype none

module nnr_checker import nnr_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   func,
	input wire logic                   done,
	input wire logic [NNR_PIX_W-1:0]   pixel_out,
	input wire logic                   in_frame
);

	// every fetch word is followed by a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_FETCH)) |-> ##4 done)
		else $error("fetch word without a result");

	// every result comes from a fetch, never from a load
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (func == FUNC_FETCH), 4))
		else $error("result word without a fetch");

	// a source outside the frame reads as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_frame) |-> (pixel_out == '0))
		else $error("non-zero pixel outside the frame");

endmodule

bind nearest_neighbor_rotate_unit nnr_checker u_nnr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.func      (func),
	.done      (done),
	.pixel_out (pixel_out),
	.in_frame  (in_frame)
);

`default_nettype wire

// File: tb/nearest_neighbor_rotate_unit_tb.sv
`timescale 1ns / 100ps

module nearest_neighbor_rotate_unit_tb;
	import nnr_pkg::*;

	localparam int STORE_W     = NNR_MAX_WIDTH;
	localparam int STORE_H     = NNR_MAX_HEIGHT;
	localparam longint HALF    = longint'(1) << NNR_TRIG_FRAC_BITS;
	localparam longint SCALE   = longint'(1) << (NNR_TRIG_FRAC_BITS + 1);
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 100;

	typedef struct {
		logic [NNR_PIX_W-1:0] pixel;
		logic                 in_bounds;
	} rotated_pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   func = 1'b0;
	logic [NNR_COORD_W-1:0] col = '0;
	logic [NNR_COORD_W-1:0] row = '0;
	logic [NNR_PIX_W-1:0]   pixel_in = '0;
	logic                   cfg_we = 1'b0;
	logic [NNR_IDX_W-1:0]   cfg_index = '0;
	logic [NNR_CFG_W-1:0]   cfg_data = '0;
	logic                   done;
	logic [NNR_PIX_W-1:0]   pixel_out;
	logic                   in_frame;

	// local copy of the frame store and registers; an entry exists once loaded
	logic [NNR_PIX_W-1:0] frame_copy [int unsigned];
	logic [NNR_DIM_W-1:0] geom_width  = NNR_RST_WIDTH;
	logic [NNR_DIM_W-1:0] geom_height = NNR_RST_HEIGHT;
	shortint              geom_cos    = NNR_RST_COSINE;
	shortint              geom_sin    = NNR_RST_SINE;

	rotated_pixel_t rotated_pixels [$];

	int  fail_count    = 0;
	int  cycle_count   = 0;
	int  load_count    = 0;
	int  fetch_count   = 0;
	int  inside_count  = 0;
	int  setting_count = 0;
	bit  steady_flow   = 1'b0;

	nearest_neighbor_rotate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.col       (col),
		.row       (row),
		.pixel_in  (pixel_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.pixel_out (pixel_out),
		.in_frame  (in_frame)
	);

	always #10 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("nearest_neighbor_rotate_unit test failed");
			$finish;
		end
	end

	// inverse rotation of a destination position back into the source frame
	function automatic void map_to_source(input logic [NNR_COORD_W-1:0] dcol,
			input logic [NNR_COORD_W-1:0] drow, output bit hit,
			output int unsigned addr);
		longint w, h, dx2, dy2, nx, ny, sc, sr;
		w = (geom_width > STORE_W) ? STORE_W : geom_width;
		h = (geom_height > STORE_H) ? STORE_H : geom_height;
		dx2 = 2 * longint'(dcol) - w;
		dy2 = h - 2 * longint'(drow);
		nx = longint'(geom_cos) * dx2 - longint'(geom_sin) * dy2 + w * HALF + HALF;
		ny = -(longint'(geom_sin) * dx2 + longint'(geom_cos) * dy2) + h * HALF + HALF;
		// integer division truncates toward zero, as the block does
		sc = nx / SCALE;
		sr = ny / SCALE;
		hit = (sc >= 0) && (sc < w) && (sr >= 0) && (sr < h);
		addr = hit ? int'(sr * STORE_W + sc) : 0;
	endfunction

	// result checker: every strobe takes the oldest predicted pixel
	always @(posedge clk) begin : check_results
		rotated_pixel_t want;
		if (arst_n && done) begin
			if (rotated_pixels.size() == 0) begin
				$error("result word with nothing pending");
				fail_count++;
			end else begin
				want = rotated_pixels.pop_front();
				if (pixel_out !== want.pixel) begin
					$error("pixel_out expected %h got %h", want.pixel, pixel_out);
					fail_count++;
				end
				if (in_frame !== want.in_bounds) begin
					$error("in_frame expected %b got %b", want.in_bounds, in_frame);
					fail_count++;
				end
			end
		end
	end

	// present one word and hold it until taken, then update the local copy
	task automatic push_word(input nnr_func_t f, input logic [NNR_COORD_W-1:0] c,
			input logic [NNR_COORD_W-1:0] r, input logic [NNR_PIX_W-1:0] p);
		int             gap;
		bit             hit;
		int unsigned    addr;
		rotated_pixel_t res;
		gap = steady_flow ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		func     <= f;
		col      <= c;
		row      <= r;
		pixel_in <= p;
		do @(posedge clk); while (busy);
		if (f == FUNC_LOAD) begin
			frame_copy[int'(r) * STORE_W + int'(c)] = p;
			load_count++;
		end else begin
			map_to_source(c, r, hit, addr);
			res.in_bounds = hit;
			res.pixel     = hit ? frame_copy[addr] : '0;
			rotated_pixels.push_back(res);
			fetch_count++;
			if (hit)
				inside_count++;
		end
	endtask

	// fetch, loading the source entry first if it has never been written
	task automatic fetch_pixel(input int c, input int r);
		bit          hit;
		int unsigned addr;
		map_to_source(c[NNR_COORD_W-1:0], r[NNR_COORD_W-1:0], hit, addr);
		if (hit && !frame_copy.exists(addr))
			push_word(FUNC_LOAD, NNR_COORD_W'(addr % STORE_W),
				NNR_COORD_W'(addr / STORE_W), $urandom);
		push_word(FUNC_FETCH, c[NNR_COORD_W-1:0], r[NNR_COORD_W-1:0], $urandom);
	endtask

	// let the pipe empty; a trailing load may still sit in the load pipe
	task automatic drain();
		start <= 1'b0;
		while (rotated_pixels.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_write(input nnr_cfg_idx_t idx, input logic [NNR_CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH:  geom_width  = data[NNR_DIM_W-1:0];
			CFG_FRAME_HEIGHT: geom_height = data[NNR_DIM_W-1:0];
			CFG_COSINE:       geom_cos    = shortint'(data);
			CFG_SINE:         geom_sin    = shortint'(data);
			default: ;
		endcase
	endtask

	// new geometry, written only with the block idle
	task automatic write_geometry(input logic [NNR_CFG_W-1:0] w,
			input logic [NNR_CFG_W-1:0] h, input logic [NNR_CFG_W-1:0] c,
			input logic [NNR_CFG_W-1:0] s);
		drain();
		cfg_write(CFG_FRAME_WIDTH, w);
		cfg_write(CFG_FRAME_HEIGHT, h);
		cfg_write(CFG_COSINE, c);
		cfg_write(CFG_SINE, s);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	// reset geometry is identity over the full store
	task automatic test_reset_identity();
		push_word(FUNC_LOAD, 9'd0, 9'd0, 32'hffff_ffff);
		push_word(FUNC_LOAD, 9'd511, 9'd511, 32'h0000_0000);
		push_word(FUNC_LOAD, 9'd511, 9'd0, 32'ha5a5_a5a5);
		push_word(FUNC_LOAD, 9'd0, 9'd511, 32'h5a5a_5a5a);
		fetch_pixel(0, 0);
		fetch_pixel(511, 511);
		fetch_pixel(511, 0);
		fetch_pixel(0, 511);
		fetch_pixel(256, 256);
	endtask

	// half turn: one step past the far edge truncates back onto column and row zero
	task automatic test_truncation_near_zero();
		write_geometry(16'd100, 16'd100, -16'sd16384, 16'sd0);
		fetch_pixel(101, 101);
		fetch_pixel(102, 102);
		fetch_pixel(101, 102);
		fetch_pixel(511, 511);
	endtask

	// zero, unit and oversized frames
	task automatic test_dimension_limits();
		write_geometry(16'd0, 16'd37, 16'sd16384, 16'sd0);
		fetch_pixel(0, 0);
		fetch_pixel(5, 5);
		write_geometry(16'hfc00 | 16'd1023, 16'd1023, 16'sd16384, 16'sd0);
		fetch_pixel(511, 511);
		fetch_pixel(0, 511);
		write_geometry(16'd1, 16'd1, 16'sd16384, 16'sd0);
		fetch_pixel(0, 0);
		fetch_pixel(1, 0);
	endtask

	// extreme trig words and a quarter turn
	task automatic test_trig_extremes();
		write_geometry(16'd64, 16'd48, 16'h8000, 16'h7fff);
		fetch_pixel(0, 0);
		fetch_pixel(63, 47);
		fetch_pixel(32, 24);
		write_geometry(16'd512, 16'd512, 16'sd0, -16'sd16384);
		fetch_pixel(0, 0);
		fetch_pixel(511, 511);
	endtask

	// random geometry per phase, mostly small frames, mixed loads and fetches
	task automatic test_random_phases();
		int                   w, h, ew, eh, pick, n;
		logic [NNR_CFG_W-1:0] wd, hd, cd, sd;
		for (int ph = 0; ph < PHASES; ph++) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 1023) : $urandom_range(1, 40);
			h = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 1023) : $urandom_range(1, 40);
			wd = NNR_CFG_W'($urandom);
			hd = NNR_CFG_W'($urandom);
			wd[NNR_DIM_W-1:0] = NNR_DIM_W'(w);
			hd[NNR_DIM_W-1:0] = NNR_DIM_W'(h);
			case ($urandom_range(0, 4))
				0: begin
					cd = 16'sd0;
					sd = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
				end
				1: begin
					cd = ($urandom_range(0, 1) != 0) ? 16'sd11585 : -16'sd11585;
					sd = ($urandom_range(0, 1) != 0) ? 16'sd11585 : -16'sd11585;
				end
				2: begin
					cd = NNR_CFG_W'($urandom);
					sd = NNR_CFG_W'($urandom);
				end
				default: begin
					cd = NNR_CFG_W'($urandom_range(0, 32768) - 16384);
					sd = NNR_CFG_W'($urandom_range(0, 32768) - 16384);
				end
			endcase
			write_geometry(wd, hd, cd, sd);
			ew = (w > STORE_W) ? STORE_W : w;
			eh = (h > STORE_H) ? STORE_H : h;
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (n % 40 == 0)
					steady_flow = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 25)
					push_word(FUNC_LOAD, NNR_COORD_W'($urandom_range(0, ew - 1)),
						NNR_COORD_W'($urandom_range(0, eh - 1)), $urandom);
				else if (pick < 35)
					push_word(FUNC_LOAD, NNR_COORD_W'($urandom_range(0, 511)),
						NNR_COORD_W'($urandom_range(0, 511)), $urandom);
				else if (pick < 85)
					fetch_pixel($urandom_range(0, (ew + 3 > 511) ? 511 : ew + 3),
						$urandom_range(0, (eh + 3 > 511) ? 511 : eh + 3));
				else
					fetch_pixel($urandom_range(0, 511), $urandom_range(0, 511));
			end
			steady_flow = 1'b0;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_truncation_near_zero();
		test_dimension_limits();
		test_trig_extremes();
		test_random_phases();
		drain();
		$display("covered %0d loads and %0d fetches, %0d of them inside the frame",
			load_count, fetch_count, inside_count);
		$display("across %0d register settings besides the reset one", setting_count);
		if (fail_count == 0)
			$display("nearest_neighbor_rotate_unit test passed");
		else
			$display("nearest_neighbor_rotate_unit test failed");
		$finish;
	end

endmodule
